/* hdl/svx_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svx_pkg
// Shared types, widths and corner helpers for the sprite quad vertex expander.
// ----------------------------------------------------------------------------
package svx_pkg;

    localparam int unsigned Q_W       = 32;
    localparam int unsigned TEX_W     = 16;
    localparam int unsigned UV_W      = 18;
    localparam int unsigned COLOR_W   = 32;
    localparam int unsigned PROD_W    = Q_W + TEX_W;
    localparam int unsigned SUM_W     = PROD_W + 2;
    localparam int unsigned SLOT_W    = 3;

    localparam logic [SLOT_W-1:0] FIRST_SLOT = 3'd0;
    localparam logic [SLOT_W-1:0] LAST_SLOT  = 3'd5;

    localparam logic [Q_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] POS_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [PROD_W-1:0]  aw;
        logic [PROD_W-1:0]  bh;
        logic [PROD_W-1:0]  cw;
        logic [PROD_W-1:0]  dh;
        logic [Q_W-1:0]     tx;
        logic [Q_W-1:0]     ty;
        logic [TEX_W-1:0]   left;
        logic [TEX_W-1:0]   top;
        logic [TEX_W-1:0]   w;
        logic [TEX_W-1:0]   h;
        logic [COLOR_W-1:0] color;
    } sprite_t;

    // slot order: TL, BL, BR, TL, BR, TR
    function automatic logic use_w(input logic [SLOT_W-1:0] slot);
        return (slot inside {3'd2, 3'd4, 3'd5});
    endfunction

    function automatic logic use_h(input logic [SLOT_W-1:0] slot);
        return (slot inside {3'd1, 3'd2, 3'd4});
    endfunction

    function automatic logic [Q_W-1:0] sat_pos(input logic [SUM_W-1:0] v);
        logic [SUM_W-Q_W:0] hi;
        hi = v[SUM_W-1:Q_W-1];
        if ((&hi) || !(|hi))
        begin
            return v[Q_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            return POS_MIN;
        end
        else
        begin
            return POS_MAX;
        end
    endfunction

endpackage

/* hdl/sprite_quad_vertex_expand_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_quad_vertex_expand_unit
// Expands one affine-transformed sprite into six triangle-list vertices.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------
//  in      | in_valid / in_stall | transform, texture rectangle, tint
//  out     | out_valid/out_stall | pos_x/y, tex_u/v, color, slot, last
//
//  Throughput is set by the single vertex output port, which carries the six vertices of each sprite in turn.
//  After the input transaction a sprite passes the front register and the queue before its first vertex is registered.
//  Front register, QUEUE_DEPTH sprite queue, then the slot sequencer.
//  Reset clears valid flags, queue pointers and the slot counter.
//  A stall on out holds the vertex; the front keeps filling the queue.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_expand_unit
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] scale_xx,
    input  logic [31:0] shear_xy,
    input  logic [31:0] shear_yx,
    input  logic [31:0] scale_yy,
    input  logic [31:0] move_x,
    input  logic [31:0] move_y,
    input  logic [15:0] tex_left,
    input  logic [15:0] tex_top,
    input  logic [15:0] tex_width,
    input  logic [15:0] tex_height,
    input  logic [31:0] tint,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] pos_x,
    output logic [31:0] pos_y,
    output logic [17:0] tex_u,
    output logic [17:0] tex_v,
    output logic [31:0] vertex_color,
    output logic [2:0]  vertex_slot,
    output logic        last
);

    svx_pkg::sprite_t front_sprite;
    svx_pkg::sprite_t queue_head;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;

    svx_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .scale_xx   (scale_xx),
        .shear_xy   (shear_xy),
        .shear_yx   (shear_yx),
        .scale_yy   (scale_yy),
        .move_x     (move_x),
        .move_y     (move_y),
        .tex_left   (tex_left),
        .tex_top    (tex_top),
        .tex_width  (tex_width),
        .tex_height (tex_height),
        .tint       (tint),
        .sprite     (front_sprite),
        .push       (push),
        .full       (full)
    );

    svx_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_sprite),
        .full    (full),
        .pop     (pop),
        .head    (queue_head),
        .empty   (empty)
    );

    svx_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (queue_head),
        .empty        (empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .vertex_color (vertex_color),
        .vertex_slot  (vertex_slot),
        .last         (last)
    );

endmodule

/* hdl/svx_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svx_front
// Accepts a sprite transaction and registers it with the four corner products.
// ----------------------------------------------------------------------------
module svx_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [31:0]           scale_xx,
    input  logic [31:0]           shear_xy,
    input  logic [31:0]           shear_yx,
    input  logic [31:0]           scale_yy,
    input  logic [31:0]           move_x,
    input  logic [31:0]           move_y,
    input  logic [15:0]           tex_left,
    input  logic [15:0]           tex_top,
    input  logic [15:0]           tex_width,
    input  logic [15:0]           tex_height,
    input  logic [31:0]           tint,
    output svx_pkg::sprite_t      sprite,
    output logic                  push,
    input  logic                  full
);

    logic             valid_reg;
    logic             valid_next;
    logic             load;
    svx_pkg::sprite_t sprite_reg;
    svx_pkg::sprite_t sprite_next;
    logic signed [svx_pkg::PROD_W-1:0] aw;
    logic signed [svx_pkg::PROD_W-1:0] bh;
    logic signed [svx_pkg::PROD_W-1:0] cw;
    logic signed [svx_pkg::PROD_W-1:0] dh;

    assign in_stall = valid_reg && full;
    assign push     = valid_reg && !full;
    assign load     = in_valid && !in_stall;
    assign sprite   = sprite_reg;

    always_comb
    begin
        aw = $signed(scale_xx) * $signed(tex_width);
        bh = $signed(shear_xy) * $signed(tex_height);
        cw = $signed(shear_yx) * $signed(tex_width);
        dh = $signed(scale_yy) * $signed(tex_height);
        sprite_next.aw    = aw;
        sprite_next.bh    = bh;
        sprite_next.cw    = cw;
        sprite_next.dh    = dh;
        sprite_next.tx    = move_x;
        sprite_next.ty    = move_y;
        sprite_next.left  = tex_left;
        sprite_next.top   = tex_top;
        sprite_next.w     = tex_width;
        sprite_next.h     = tex_height;
        sprite_next.color = tint;
        valid_next = load || (valid_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sprite_reg <= sprite_next;
        end
    end

endmodule

/* hdl/svx_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svx_queue
// Short FIFO of sprites with their corner products between the front and back parts.
// ----------------------------------------------------------------------------
module svx_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  svx_pkg::sprite_t wr_data,
    output logic             full,
    input  logic             pop,
    output svx_pkg::sprite_t head,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    svx_pkg::sprite_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hdl/svx_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svx_back
// Walks the six vertex slots of the head sprite, one vertex per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module svx_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  svx_pkg::sprite_t head,
    input  logic             empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [31:0]      pos_x,
    output logic [31:0]      pos_y,
    output logic [17:0]      tex_u,
    output logic [17:0]      tex_v,
    output logic [31:0]      vertex_color,
    output logic [2:0]       vertex_slot,
    output logic             last
);

    localparam int unsigned SUM_W = svx_pkg::SUM_W;
    localparam int unsigned PROD_W = svx_pkg::PROD_W;
    localparam int unsigned Q_W = svx_pkg::Q_W;
    localparam int unsigned UV_W = svx_pkg::UV_W;
    localparam int unsigned TEX_W = svx_pkg::TEX_W;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [svx_pkg::SLOT_W-1:0]    slot_reg;
    logic [svx_pkg::SLOT_W-1:0]    slot_next;
    logic [Q_W-1:0]                pos_x_reg;
    logic [Q_W-1:0]                pos_y_reg;
    logic [UV_W-1:0]               tex_u_reg;
    logic [UV_W-1:0]               tex_v_reg;
    logic [svx_pkg::COLOR_W-1:0]   color_reg;
    logic [svx_pkg::SLOT_W-1:0]    slot_out_reg;
    logic                          last_reg;

    logic                          advance;
    logic                          emit;
    logic                          at_last;
    logic                          sel_w;
    logic                          sel_h;
    logic [PROD_W-1:0]             ax;
    logic [PROD_W-1:0]             by;
    logic [PROD_W-1:0]             cx;
    logic [PROD_W-1:0]             dy;
    logic [SUM_W-1:0]              sum_x;
    logic [SUM_W-1:0]              sum_y;
    logic [UV_W-1:0]               du;
    logic [UV_W-1:0]               dv;

    assign advance = !out_valid_reg || !out_stall;
    assign emit    = advance && !empty;
    assign at_last = (slot_reg == svx_pkg::LAST_SLOT);
    assign pop     = emit && at_last;

    always_comb
    begin
        sel_w = svx_pkg::use_w(slot_reg);
        sel_h = svx_pkg::use_h(slot_reg);
        ax = sel_w ? head.aw : '0;
        cx = sel_w ? head.cw : '0;
        by = sel_h ? head.bh : '0;
        dy = sel_h ? head.dh : '0;
        sum_x = {{(SUM_W-PROD_W){ax[PROD_W-1]}}, ax}
              + {{(SUM_W-PROD_W){by[PROD_W-1]}}, by}
              + {{(SUM_W-Q_W){head.tx[Q_W-1]}}, head.tx};
        sum_y = {{(SUM_W-PROD_W){cx[PROD_W-1]}}, cx}
              + {{(SUM_W-PROD_W){dy[PROD_W-1]}}, dy}
              + {{(SUM_W-Q_W){head.ty[Q_W-1]}}, head.ty};
        du = sel_w ? {{(UV_W-TEX_W){head.w[TEX_W-1]}}, head.w} : '0;
        dv = sel_h ? {{(UV_W-TEX_W){head.h[TEX_W-1]}}, head.h} : '0;
        slot_next = slot_reg;
        if (emit)
        begin
            slot_next = at_last ? svx_pkg::FIRST_SLOT : slot_reg + 1'b1;
        end
        out_valid_next = emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            slot_reg      <= svx_pkg::FIRST_SLOT;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            slot_reg      <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pos_x_reg    <= svx_pkg::sat_pos(sum_x);
            pos_y_reg    <= svx_pkg::sat_pos(sum_y);
            tex_u_reg    <= {{(UV_W-TEX_W){1'b0}}, head.left} + du;
            tex_v_reg    <= {{(UV_W-TEX_W){1'b0}}, head.top} + dv;
            color_reg    <= head.color;
            slot_out_reg <= slot_reg;
            last_reg     <= at_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign tex_u        = tex_u_reg;
    assign tex_v        = tex_v_reg;
    assign vertex_color = color_reg;
    assign vertex_slot  = slot_out_reg;
    assign last         = last_reg;

endmodule

/* hdl/svx_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svx_checker
// Port-level checks on the vertex stream, bound to the top level.
// ----------------------------------------------------------------------------
module svx_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] pos_x,
    input logic [31:0] vertex_color,
    input logic [2:0]  vertex_slot,
    input logic        last
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(vertex_slot))
        else $error("vertex changed while stalled");

    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (vertex_slot == svx_pkg::LAST_SLOT)))
        else $error("last flag does not match final slot");

    a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last
        |=> out_valid && (vertex_slot == $past(vertex_slot) + 3'd1))
        else $error("vertex slots not consecutive within sprite");

    a_color_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> $stable(vertex_color))
        else $error("color changed within sprite");

endmodule

bind sprite_quad_vertex_expand_unit svx_checker u_svx_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pos_x        (pos_x),
    .vertex_color (vertex_color),
    .vertex_slot  (vertex_slot),
    .last         (last)
);
